@@ src/pcs_pkg.sv @@
// Shared types and constants for the PID controller step unit.
// Depends on nothing; every module of the unit imports it.
package pcs_pkg;

	localparam int unsigned SumWidthDef = 48;
	localparam int unsigned DataW       = 32;
	localparam int unsigned ErrW        = 33;
	localparam int unsigned DiffW       = 34;
	localparam int unsigned FracW       = 16;
	localparam int unsigned CfgIdxW     = 2;

	typedef enum logic {
		OP_STEP  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_PROP_GAIN  = 2'd0,
		REG_INT_EN     = 2'd1,
		REG_INT_RECIP  = 2'd2,
		REG_DERIV_GAIN = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		op_t                     op;
		logic signed [DataW-1:0] setpoint;
		logic signed [DataW-1:0] measured;
	} item_t;

	typedef struct packed {
		logic signed [DataW-1:0] control;
		logic signed [DataW-1:0] prop_part;
		logic signed [DataW-1:0] integral_part;
		logic signed [DataW-1:0] deriv_part;
		logic                    saturated;
	} result_t;

	typedef struct packed {
		logic signed [DataW-1:0] prop_gain;
		logic                    int_en;
		logic signed [DataW-1:0] int_recip;
		logic signed [DataW-1:0] deriv_gain;
	} cfg_t;

	typedef struct packed {
		logic clr;
		logic int_en;
		logic sat;
	} step_ctl_t;

endpackage

@@ src/pcs_floor_sat.sv @@
// Floor a product with 2*FracW fraction bits down to Q16.16 and clip to 32 bits.
// Depends on pcs_pkg.
module pcs_floor_sat import pcs_pkg::*; #(
	parameter int unsigned PW = 65
) (
	input  logic signed [PW-1:0]    prod,
	output logic signed [DataW-1:0] q,
	output logic                    sat
);

	logic [PW-1-(FracW+DataW-1):0] top_bits;
	logic                          fits;

	assign top_bits = prod[PW-1:FracW+DataW-1];
	assign fits     = (&top_bits) | ~(|top_bits);
	assign sat      = ~fits;

	always_comb begin
		if (fits) begin
			q = prod[FracW+DataW-1:FracW];
		end else if (prod[PW-1]) begin
			q = {1'b1, {(DataW-1){1'b0}}};
		end else begin
			q = {1'b0, {(DataW-1){1'b1}}};
		end
	end

endmodule

@@ src/pcs_front.sv @@
// Error, error difference and saturating error sum; holds prev error and the sum.
// Depends on pcs_pkg.
module pcs_front import pcs_pkg::*; #(
	parameter int unsigned SUM_WIDTH = SumWidthDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        valid_s1,
	input  item_t                       item_s1,
	input  logic                        int_en,
	output logic                        valid_s2,
	output step_ctl_t                   ctl_s2,
	output logic signed [ErrW-1:0]      err_s2,
	output logic signed [DiffW-1:0]     diff_s2,
	output logic signed [SUM_WIDTH-1:0] sum_s2
);

	logic signed [SUM_WIDTH-1:0] error_sum_q;
	logic signed [ErrW-1:0]      prev_error_q;
	logic [ErrW-1:0]             err;
	logic [DiffW-1:0]            diff;
	logic [SUM_WIDTH:0]          sum_ext;
	logic                        ovf;
	logic [SUM_WIDTH-1:0]        sum_next;
	logic                        is_clr;

	assign is_clr = (item_s1.op == OP_CLEAR);
	assign err    = {item_s1.setpoint[DataW-1], item_s1.setpoint}
	              - {item_s1.measured[DataW-1], item_s1.measured};
	assign diff   = {err[ErrW-1], err} - {prev_error_q[ErrW-1], prev_error_q};
	assign sum_ext = {error_sum_q[SUM_WIDTH-1], error_sum_q}
	               + {{(SUM_WIDTH+1-ErrW){err[ErrW-1]}}, err};
	assign ovf     = sum_ext[SUM_WIDTH] ^ sum_ext[SUM_WIDTH-1];

	always_comb begin
		if (!ovf) begin
			sum_next = sum_ext[SUM_WIDTH-1:0];
		end else if (sum_ext[SUM_WIDTH]) begin
			sum_next = {1'b1, {(SUM_WIDTH-1){1'b0}}};
		end else begin
			sum_next = {1'b0, {(SUM_WIDTH-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			prev_error_q <= '0;
		end else if (adv && valid_s1) begin
			if (is_clr) begin
				error_sum_q  <= '0;
				prev_error_q <= '0;
			end else begin
				prev_error_q <= err;
				if (int_en) begin
					error_sum_q <= sum_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2.clr    <= is_clr;
			ctl_s2.int_en <= int_en;
			ctl_s2.sat    <= int_en & ovf & ~is_clr;
			err_s2        <= err;
			diff_s2       <= diff;
		end
	end

	// the sum register always matches the item held in the second stage
	assign sum_s2 = error_sum_q;

	a_clear_zeroes_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && is_clr |=> error_sum_q == '0 && prev_error_q == '0)
		else $error("clear item left state nonzero");

	a_disabled_holds_sum: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && !int_en && !is_clr |=> $stable(error_sum_q))
		else $error("error sum moved while integral disabled");

endmodule

@@ src/pcs_back.sv @@
// Three gain products (integral split in two halves), then floor and clip to parts.
// Depends on pcs_pkg and pcs_floor_sat.
module pcs_back import pcs_pkg::*; #(
	parameter int unsigned SUM_WIDTH = SumWidthDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  cfg_t                        cfg,
	input  logic                        valid_s2,
	input  step_ctl_t                   ctl_s2,
	input  logic signed [ErrW-1:0]      err_s2,
	input  logic signed [DiffW-1:0]     diff_s2,
	input  logic signed [SUM_WIDTH-1:0] sum_s2,
	output logic                        valid_s4,
	output step_ctl_t                   ctl_s4,
	output logic signed [DataW-1:0]     prop_s4,
	output logic signed [DataW-1:0]     int_s4,
	output logic signed [DataW-1:0]     deriv_s4
);

	localparam int unsigned LoW = SUM_WIDTH / 2;
	localparam int unsigned HiW = SUM_WIDTH - LoW;
	localparam int unsigned PpW = DataW + ErrW;
	localparam int unsigned PdW = DataW + DiffW;
	localparam int unsigned PlW = DataW + LoW + 1;
	localparam int unsigned PhW = DataW + HiW;
	localparam int unsigned IW  = DataW + SUM_WIDTH;

	logic              valid_s3;
	step_ctl_t         ctl_s3;
	logic signed [PpW-1:0] prod_p_s3;
	logic signed [PdW-1:0] prod_d_s3;
	logic signed [PlW-1:0] prod_il_s3;
	logic signed [PhW-1:0] prod_ih_s3;
	logic signed [IW-1:0]  int_full;
	logic signed [DataW-1:0] p_q, i_q, d_q;
	logic              p_sat, i_sat, d_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3     <= ctl_s2;
			prod_p_s3  <= cfg.prop_gain * err_s2;
			prod_d_s3  <= cfg.deriv_gain * diff_s2;
			prod_il_s3 <= cfg.int_recip * $signed({1'b0, sum_s2[LoW-1:0]});
			prod_ih_s3 <= cfg.int_recip * $signed(sum_s2[SUM_WIDTH-1:LoW]);
		end
	end

	assign int_full = (IW'(prod_ih_s3) <<< LoW) + IW'(prod_il_s3);

	pcs_floor_sat #(.PW(PpW)) u_sat_p (.prod(prod_p_s3), .q(p_q), .sat(p_sat));
	pcs_floor_sat #(.PW(IW))  u_sat_i (.prod(int_full),  .q(i_q), .sat(i_sat));
	pcs_floor_sat #(.PW(PdW)) u_sat_d (.prod(prod_d_s3), .q(d_q), .sat(d_sat));

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4.clr    <= ctl_s3.clr;
			ctl_s4.int_en <= ctl_s3.int_en;
			ctl_s4.sat    <= ~ctl_s3.clr
			               & (ctl_s3.sat | p_sat | d_sat | (ctl_s3.int_en & i_sat));
			prop_s4       <= ctl_s3.clr ? '0 : p_q;
			int_s4        <= (ctl_s3.clr || !ctl_s3.int_en) ? '0 : i_q;
			deriv_s4      <= ctl_s3.clr ? '0 : d_q;
		end
	end

	a_int_zero_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s3 && !ctl_s3.int_en |=> int_s4 == '0)
		else $error("integral part nonzero while disabled");

endmodule

@@ src/pid_controller_step_unit.sv @@
// Top level of the PID controller step unit: config registers, input and result stages.
// Depends on pcs_pkg, pcs_front, pcs_back (and pcs_floor_sat below it).
//
// channel   direction  handshake                   payload
// item      in         item_valid / item_stall     item_t   (op, setpoint, measured)
// result    out        result_valid / result_stall result_t (control, parts, saturated)
// cfg       in         cfg_wr_en                   cfg_index, cfg_wdata
//
// One item per cycle unless a stalled result holds the pipeline.
// Each item passes five register stages: input, error/sum, products, parts, result.
// Reset clears valid flags, config registers, error sum and previous error.
// A stalled result holds the whole pipeline; item_stall is set only while a valid result is stalled.
module pid_controller_step_unit import pcs_pkg::*; #(
	parameter int unsigned SUM_WIDTH = SumWidthDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               cfg_wr_en,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DataW-1:0]   cfg_wdata
);

	cfg_t                        cfg_q;
	logic                        adv;
	logic                        valid_s1;
	item_t                       item_s1;
	logic                        valid_s2;
	step_ctl_t                   ctl_s2;
	logic signed [ErrW-1:0]      err_s2;
	logic signed [DiffW-1:0]     diff_s2;
	logic signed [SUM_WIDTH-1:0] sum_s2;
	logic                        valid_s4;
	step_ctl_t                   ctl_s4;
	logic signed [DataW-1:0]     prop_s4, int_s4, deriv_s4;
	logic [DataW+1:0]            csum;
	logic                        csat;
	result_t                     result_next;

	assign adv        = ~result_valid | ~result_stall;
	assign item_stall = ~adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PROP_GAIN:  cfg_q.prop_gain  <= cfg_wdata;
				REG_INT_EN:     cfg_q.int_en     <= cfg_wdata[0];
				REG_INT_RECIP:  cfg_q.int_recip  <= cfg_wdata;
				REG_DERIV_GAIN: cfg_q.deriv_gain <= cfg_wdata;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item;
		end
	end

	pcs_front #(.SUM_WIDTH(SUM_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.int_en   (cfg_q.int_en),
		.valid_s2 (valid_s2),
		.ctl_s2   (ctl_s2),
		.err_s2   (err_s2),
		.diff_s2  (diff_s2),
		.sum_s2   (sum_s2)
	);

	pcs_back #(.SUM_WIDTH(SUM_WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.cfg      (cfg_q),
		.valid_s2 (valid_s2),
		.ctl_s2   (ctl_s2),
		.err_s2   (err_s2),
		.diff_s2  (diff_s2),
		.sum_s2   (sum_s2),
		.valid_s4 (valid_s4),
		.ctl_s4   (ctl_s4),
		.prop_s4  (prop_s4),
		.int_s4   (int_s4),
		.deriv_s4 (deriv_s4)
	);

	assign csum = {{2{prop_s4[DataW-1]}}, prop_s4}
	            + {{2{int_s4[DataW-1]}}, int_s4}
	            + {{2{deriv_s4[DataW-1]}}, deriv_s4};
	assign csat = ~((&csum[DataW+1:DataW-1]) | ~(|csum[DataW+1:DataW-1]));

	always_comb begin
		result_next.prop_part     = prop_s4;
		result_next.integral_part = int_s4;
		result_next.deriv_part    = deriv_s4;
		result_next.saturated     = ctl_s4.sat | csat;
		if (!csat) begin
			result_next.control = csum[DataW-1:0];
		end else if (csum[DataW+1]) begin
			result_next.control = {1'b1, {(DataW-1){1'b0}}};
		end else begin
			result_next.control = {1'b0, {(DataW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result <= result_next;
		end
	end

	a_clear_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s4 && ctl_s4.clr |=> result.control == '0 && !result.saturated)
		else $error("clear item produced a nonzero result");

endmodule

@@ sim/pid_step_checker.sv @@
// Checker for the PID controller step unit: snoops the register port and both channels,
// predicts each result from its item and compares it field by field. Depends on pcs_pkg.
module pid_step_checker import pcs_pkg::*; #(
	parameter int unsigned SUM_WIDTH = SumWidthDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  item_t              item,
	input  logic               result_valid,
	input  logic               result_stall,
	input  result_t            result,
	input  logic               cfg_wr_en,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DataW-1:0]   cfg_wdata,
	output int                 mismatches,
	output int                 outstanding
);

	localparam logic signed [127:0] Max32  = 128'sh7FFF_FFFF;
	localparam logic signed [127:0] Min32  = -Max32 - 128'sd1;
	localparam logic signed [127:0] SumMax = (128'sd1 <<< (SUM_WIDTH - 1)) - 128'sd1;
	localparam logic signed [127:0] SumMin = -SumMax - 128'sd1;

	cfg_t                        gains;
	logic signed [SUM_WIDTH-1:0] err_acc;
	logic signed [ErrW-1:0]      last_err;
	result_t                     ctrl_due[$];
	result_t                     want;
	int                          bad = 0;

	assign mismatches = bad;

	function automatic logic signed [127:0] clamp32(logic signed [127:0] v, inout logic clip);
		if (v > Max32) begin
			clip = 1'b1;
			return Max32;
		end
		if (v < Min32) begin
			clip = 1'b1;
			return Min32;
		end
		return v;
	endfunction

	function automatic logic signed [127:0] scale_q16(logic signed [DataW-1:0] gain,
			logic signed [127:0] val, inout logic clip);
		logic signed [127:0] g;
		g = gain;
		return clamp32((g * val) >>> FracW, clip);
	endfunction

	function automatic result_t pid_step(item_t it);
		result_t             r;
		logic                clip;
		logic signed [127:0] sp, ms, err, old, acc, p, i, d, c;
		r = '0;
		clip = 1'b0;
		if (it.op == OP_CLEAR) begin
			err_acc = '0;
			last_err = '0;
			return r;
		end
		sp = it.setpoint;
		ms = it.measured;
		err = sp - ms;
		p = scale_q16(gains.prop_gain, err, clip);
		i = '0;
		if (gains.int_en) begin
			acc = err_acc;
			acc = acc + err;
			if (acc > SumMax) begin
				acc = SumMax;
				clip = 1'b1;
			end else if (acc < SumMin) begin
				acc = SumMin;
				clip = 1'b1;
			end
			err_acc = acc[SUM_WIDTH-1:0];
			i = scale_q16(gains.int_recip, acc, clip);
		end
		old = last_err;
		d = scale_q16(gains.deriv_gain, err - old, clip);
		last_err = err[ErrW-1:0];
		c = clamp32(p + i + d, clip);
		r.control = c[DataW-1:0];
		r.prop_part = p[DataW-1:0];
		r.integral_part = i[DataW-1:0];
		r.deriv_part = d[DataW-1:0];
		r.saturated = clip;
		return r;
	endfunction

	task automatic flag(string what, logic [DataW-1:0] want_v, logic [DataW-1:0] got_v);
		if (bad < 10)
			$display("%0t mismatch in %s: expected %h got %h", $time, what, want_v, got_v);
		bad++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains = '0;
			err_acc = '0;
			last_err = '0;
			ctrl_due.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_PROP_GAIN:  gains.prop_gain = cfg_wdata;
					REG_INT_EN:     gains.int_en = cfg_wdata[0];
					REG_INT_RECIP:  gains.int_recip = cfg_wdata;
					REG_DERIV_GAIN: gains.deriv_gain = cfg_wdata;
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (ctrl_due.size() == 0) begin
					flag("result with nothing expected", '0, result.control);
				end else begin
					want = ctrl_due.pop_front();
					if (result.control !== want.control)
						flag("control", want.control, result.control);
					if (result.prop_part !== want.prop_part)
						flag("prop_part", want.prop_part, result.prop_part);
					if (result.integral_part !== want.integral_part)
						flag("integral_part", want.integral_part, result.integral_part);
					if (result.deriv_part !== want.deriv_part)
						flag("deriv_part", want.deriv_part, result.deriv_part);
					if (result.saturated !== want.saturated)
						flag("saturated", want.saturated, result.saturated);
				end
			end
			if (item_valid && !item_stall)
				ctrl_due.push_back(pid_step(item));
			outstanding <= ctrl_due.size();
		end
	end

endmodule

@@ sim/tb_pid_controller_step_unit.sv @@
// Testbench top for the PID controller step unit: drives items, gains and result stalls,
// and gives the verdict. Depends on pcs_pkg, pid_controller_step_unit and pid_step_checker.
module tb_pid_controller_step_unit;
	import pcs_pkg::*;

	localparam int unsigned SumW       = SumWidthDef;
	localparam int unsigned CycleLimit = 1_000_000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	item_t              item = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	result_t            result;
	logic               cfg_wr_en = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [DataW-1:0]   cfg_wdata = '0;
	int                 mismatches;
	int                 outstanding;
	int                 send_idle = 0;
	int                 recv_idle = 0;
	int unsigned        cycle_count = 0;

	always #1 clk = ~clk;

	pid_controller_step_unit #(.SUM_WIDTH(SumW)) dut (
		.clk, .arst_n, .item_valid, .item_stall, .item, .result_valid, .result_stall,
		.result, .cfg_wr_en, .cfg_index, .cfg_wdata
	);

	pid_step_checker #(.SUM_WIDTH(SumW)) chk (
		.clk, .arst_n, .item_valid, .item_stall, .item, .result_valid, .result_stall,
		.result, .cfg_wr_en, .cfg_index, .cfg_wdata, .mismatches, .outstanding
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_stall <= 1'b0;
		else
			result_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send(op_t op, logic [DataW-1:0] sp, logic [DataW-1:0] ms);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{op: op, setpoint: sp, measured: ms};
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_gains(logic [DataW-1:0] pg, logic [DataW-1:0] en_word,
			logic [DataW-1:0] ri, logic [DataW-1:0] dg);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_PROP_GAIN;
		cfg_wdata <= pg;
		@(posedge clk);
		cfg_index <= REG_INT_EN;
		cfg_wdata <= en_word;
		@(posedge clk);
		cfg_index <= REG_INT_RECIP;
		cfg_wdata <= ri;
		@(posedge clk);
		cfg_index <= REG_DERIV_GAIN;
		cfg_wdata <= dg;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [DataW-1:0] sp, ms, delta, pg, ri, dg, en_word;
		int unsigned      roll;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
		send(OP_STEP, 32'h1234_5678, 32'h0001_0000);
		settle();
		load_gains(32'h0001_0000, 32'h1, 32'h0001_0000, 32'h0001_0000);
		send(OP_STEP, 32'h0, 32'h0);
		send(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
		send(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
		send(OP_STEP, 32'h0000_0001, 32'h0000_0002);
		send(OP_STEP, 32'h0001_0000, 32'h0001_0000);
		send(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(OP_STEP, 32'h0000_8000, 32'h0);
		settle();
		load_gains(32'h0000_8000, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_8000);
		send(OP_STEP, 32'h0000_0003, 32'h0);
		send(OP_STEP, 32'hFFFF_FFFD, 32'h0);
		send(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
		send(OP_CLEAR, 32'h0, 32'h0);
		send(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
		settle();
		load_gains(32'h8000_0000, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF);
		send(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
		send(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
		send(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
		send(OP_STEP, 32'h0, 32'h0);
		send(OP_CLEAR, 32'h5555_5555, 32'hAAAA_AAAA);
		send(OP_STEP, 32'hAAAA_AAAA, 32'h5555_5555);

		for (int prof = 0; prof < 3; prof++) begin
			for (int mode = 0; mode < 4; mode++) begin
				settle();
				case (prof)
					0: begin
						send_idle = 8;
						recv_idle = 65;
					end
					1: begin
						send_idle = 65;
						recv_idle = 8;
					end
					default: begin
						send_idle = 0;
						recv_idle = 0;
					end
				endcase
				case (mode)
					0: begin
						pg = $urandom_range(0, 32'h3FFFF) - 32'h20000;
						en_word = 32'h1;
						ri = $urandom_range(0, 32'h3FFF) - 32'h2000;
						dg = $urandom_range(0, 32'h3FFFF) - 32'h20000;
					end
					1: begin
						pg = $urandom();
						en_word = $urandom() & ~32'h1;
						ri = $urandom();
						dg = $urandom();
					end
					2: begin
						pg = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
						en_word = 32'h1;
						ri = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
						dg = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					end
					default: begin
						pg = $urandom();
						en_word = $urandom();
						ri = $urandom();
						dg = $urandom();
					end
				endcase
				load_gains(pg, en_word, ri, dg);
				repeat (140) begin
					roll = $urandom_range(99);
					sp = $urandom();
					delta = $urandom_range(0, 32'h3FFFF) - 32'h20000;
					ms = (roll < 60) ? sp + delta : $urandom();
					send((roll >= 97) ? OP_CLEAR : OP_STEP, sp, ms);
				end
			end
		end

		settle();
		load_gains(32'h0001_0000, 32'h1, $urandom_range(0, 32'hFFFF), 32'h0001_0000);
		send(OP_CLEAR, 32'h0, 32'h0);
		repeat (140)
			send(OP_STEP, {16'h7FFF, 16'($urandom())}, {16'h8000, 16'($urandom())});
		send(OP_CLEAR, 32'h0, 32'h0);
		repeat (140)
			send(OP_STEP, {16'h8000, 16'($urandom())}, {16'h7FFF, 16'($urandom())});

		settle();
		if (mismatches == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
